[rtl/sseext_pkg.sv]
// ----------------------------------------------------------------------------
// sseext_pkg
// Shared types and constants for the server-sent-events data extractor.
// ----------------------------------------------------------------------------
package sseext_pkg;

    // Result queue depth; must be at least 3 so two results fit behind one.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Input item kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Result kinds
    localparam logic OUT_PAYLOAD = 1'b0;
    localparam logic OUT_MARKER  = 1'b1;

    // Byte-order mark and line characters
    localparam logic [7:0] BOM_B0     = 8'hEF;
    localparam logic [7:0] BOM_B1     = 8'hBB;
    localparam logic [7:0] BOM_B2     = 8'hBF;
    localparam logic [1:0] BOM_DONE   = 2'd3;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_D     = 8'h64;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_T     = 8'h74;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Where the parser is within the current line
    typedef enum logic [3:0] {
        PH_START = 4'd0,   // line start
        PH_D     = 4'd1,   // "d"
        PH_DA    = 4'd2,   // "da"
        PH_DAT   = 4'd3,   // "dat"
        PH_DATA  = 4'd4,   // "data"
        PH_COLON = 4'd5,   // "data:"
        PH_VALUE = 4'd6,   // inside the value
        PH_SKIP  = 4'd7    // not a data line, skip to line end
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] bom;
        logic       pending_cr;
        logic       nonempty;
    } parse_state_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;   // 0..2 results from this beat
        result_t    r0;      // first result
        result_t    r1;      // second result, valid when count is 2
    } step_out_t;

    function automatic logic [7:0] bom_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = BOM_B0;
            2'd1:    b = BOM_B1;
            default: b = BOM_B2;
        endcase
        return b;
    endfunction

endpackage

[rtl/sseext_step.sv]
// ----------------------------------------------------------------------------
// sseext_step
// Per-beat parse step: next parser state and up to two results.
// ----------------------------------------------------------------------------
module sseext_step (
    input  logic                     kind,
    input  logic [7:0]               stream_byte,
    input  sseext_pkg::parse_state_t cur,
    output sseext_pkg::parse_state_t nxt,
    output sseext_pkg::step_out_t    res
);
    import sseext_pkg::*;

    logic   is_flush;
    logic   bom_active;
    logic   bom_hit;
    logic   bom_break;
    logic   is_cr;
    logic   is_lf;
    logic   eol;
    logic   lf_swallow;
    logic   byte_go;
    phase_t eff_phase;
    logic   a_valid;
    logic   b_valid;
    result_t a_res;
    result_t b_res;

    assign is_flush   = (kind == KIND_FLUSH);
    assign bom_active = (cur.bom != BOM_DONE);
    assign bom_hit    = !is_flush && bom_active && (stream_byte == bom_byte(cur.bom));
    // a mark broken after one or two bytes leaves a line that cannot be data
    assign bom_break  = !is_flush && bom_active && !bom_hit && (cur.bom != 2'd0);
    assign eff_phase  = bom_break ? PH_SKIP : cur.phase;
    assign is_cr      = (stream_byte == CHAR_CR);
    assign is_lf      = (stream_byte == CHAR_LF);
    assign eol        = !is_flush && !bom_hit && (is_cr || (is_lf && !cur.pending_cr));
    assign lf_swallow = !is_flush && !bom_hit && is_lf && cur.pending_cr;
    assign byte_go    = !is_flush && !bom_hit && !is_cr && !is_lf;

    // next state
    always_comb
    begin
        nxt = cur;
        if (is_flush)
        begin
            nxt.phase      = PH_START;
            nxt.bom        = 2'd0;
            nxt.pending_cr = 1'b0;
            nxt.nonempty   = 1'b0;
        end
        else if (bom_hit)
        begin
            nxt.bom = cur.bom + 2'd1;
        end
        else
        begin
            nxt.bom = BOM_DONE;
            if (eol)
            begin
                nxt.phase      = PH_START;
                nxt.pending_cr = is_cr;
                if (eff_phase == PH_START)
                    nxt.nonempty = 1'b0;
            end
            else if (lf_swallow)
            begin
                nxt.phase      = eff_phase;
                nxt.pending_cr = 1'b0;
            end
            else
            begin
                nxt.pending_cr = 1'b0;
                unique case (eff_phase)
                    PH_START: nxt.phase = (stream_byte == CHAR_D)     ? PH_D     : PH_SKIP;
                    PH_D:     nxt.phase = (stream_byte == CHAR_A)     ? PH_DA    : PH_SKIP;
                    PH_DA:    nxt.phase = (stream_byte == CHAR_T)     ? PH_DAT   : PH_SKIP;
                    PH_DAT:   nxt.phase = (stream_byte == CHAR_A)     ? PH_DATA  : PH_SKIP;
                    PH_DATA:  nxt.phase = (stream_byte == CHAR_COLON) ? PH_COLON : PH_SKIP;
                    PH_COLON:
                    begin
                        nxt.phase = PH_VALUE;
                        if (stream_byte != CHAR_SPACE)
                            nxt.nonempty = 1'b1;
                    end
                    PH_VALUE: nxt.nonempty = 1'b1;
                    default:  nxt.phase = PH_SKIP;
                endcase
            end
        end
    end

    // results: a = separator slot, b = payload byte or marker slot
    always_comb
    begin
        a_valid = 1'b0;
        b_valid = 1'b0;
        a_res   = '{kind: OUT_PAYLOAD, data: CHAR_LF, last: 1'b0};
        b_res   = '{kind: OUT_MARKER, data: 8'h00, last: 1'b1};
        if (is_flush)
        begin
            a_valid = cur.nonempty && (cur.phase == PH_DATA || cur.phase == PH_COLON);
            b_valid = cur.nonempty;
        end
        else if (eol)
        begin
            if (eff_phase == PH_START)
                b_valid = cur.nonempty;
            else if (eff_phase == PH_DATA || eff_phase == PH_COLON)
                a_valid = cur.nonempty;
        end
        else if (byte_go)
        begin
            b_res.kind = OUT_PAYLOAD;
            b_res.data = stream_byte;
            if (eff_phase == PH_COLON)
            begin
                a_valid = cur.nonempty;
                b_valid = (stream_byte != CHAR_SPACE);
            end
            else if (eff_phase == PH_VALUE)
            begin
                b_valid = 1'b1;
            end
        end

        res.count   = {1'b0, a_valid} + {1'b0, b_valid};
        res.r0      = a_valid ? a_res : b_res;
        res.r0.last = !(a_valid && b_valid);
        res.r1      = b_res;
    end

endmodule

[rtl/sse_event_data_extractor.sv]
// ----------------------------------------------------------------------------
// sse_event_data_extractor
// Server-sent-events byte stream parser that passes on data-line payload.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one beat per stream byte (kind 0) or
//   an end-of-stream flush (kind 1). Output channel (out_valid / out_stall):
//   one beat per result, a payload byte or separator LF (out_kind 0) or an
//   event complete marker (out_kind 1); last_of_run flags the final result
//   caused by an input beat.
//   Each input beat is parsed in the cycle it is accepted and its zero, one
//   or two results enter a small result queue; the first result is visible
//   on the output the cycle after acceptance when the queue was empty.
//   Throughput: one input beat per cycle while each beat yields at most one
//   result and the receiver does not stall; a beat with two results holds
//   the output for both, as the result queue has a single output port.
//   in_stall rises when the queue lacks room for two results, so a stalled
//   receiver backs up into the input after a few beats; nothing is dropped.
//   Reset (rst_n low) empties the queue and returns the parser to stream
//   start, with the byte-order mark check armed again.
// ----------------------------------------------------------------------------
module sse_event_data_extractor #(
    parameter int unsigned QUEUE_DEPTH = sseext_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] stream_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       out_kind,
    output logic [7:0] payload_byte,
    output logic       last_of_run
);
    import sseext_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    // parser state
    parse_state_t state_reg;
    parse_state_t state_next;
    step_out_t    step_res;

    // result queue
    result_t          queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic in_accept;
    logic out_accept;
    logic [CNT_W-1:0] push_n;

    // pointer advance with wrap, for any queue depth
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                                 input logic [1:0]       n);
        logic [PTR_W+1:0] sum;
        sum = {2'b00, ptr} + {{PTR_W{1'b0}}, n};
        if (sum >= (PTR_W + 2)'(QUEUE_DEPTH))
            sum = sum - (PTR_W + 2)'(QUEUE_DEPTH);
        return sum[PTR_W-1:0];
    endfunction

    sseext_step u_step (
        .kind        (kind),
        .stream_byte (stream_byte),
        .cur         (state_reg),
        .nxt         (state_next),
        .res         (step_res)
    );

    // room for the worst case of two results keeps the input side simple
    assign in_stall   = (count_reg > CNT_W'(QUEUE_DEPTH - 2));
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = (count_reg != '0);
    assign out_accept = out_valid && !out_stall;

    assign push_n       = in_accept ? CNT_W'(step_res.count) : '0;
    assign wr_ptr_plus1 = ptr_add(wr_ptr_reg, 2'd1);
    assign wr_ptr_next  = in_accept ? ptr_add(wr_ptr_reg, step_res.count) : wr_ptr_reg;
    assign rd_ptr_next  = out_accept ? ptr_add(rd_ptr_reg, 2'd1) : rd_ptr_reg;
    assign count_next   = count_reg + push_n - CNT_W'(out_accept);

    // head of queue drives the output beat
    assign out_kind     = queue_reg[rd_ptr_reg].kind;
    assign payload_byte = queue_reg[rd_ptr_reg].data;
    assign last_of_run  = queue_reg[rd_ptr_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= '{phase: PH_START, bom: 2'd0, pending_cr: 1'b0, nonempty: 1'b0};
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_accept)
                state_reg <= state_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept && step_res.count != 2'd0)
            queue_reg[wr_ptr_reg] <= step_res.r0;
        if (in_accept && step_res.count == 2'd2)
            queue_reg[wr_ptr_plus1] <= step_res.r1;
    end

endmodule

[rtl/sseext_checker.sv]
// ----------------------------------------------------------------------------
// sseext_checker
// Port-level checks for the server-sent-events data extractor.
// ----------------------------------------------------------------------------
module sseext_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       kind,
    input logic [7:0] stream_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic       out_kind,
    input logic [7:0] payload_byte,
    input logic       last_of_run
);
    import sseext_pkg::*;

    // stalled input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(kind) && $stable(stream_byte))
        else $error("input beat changed while stalled");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_kind)
            && $stable(payload_byte) && $stable(last_of_run))
        else $error("output beat changed while stalled");

    // marker closes the run of its input beat
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == OUT_MARKER) |-> last_of_run)
        else $error("event marker not last of run");

    // marker carries a zero byte
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == OUT_MARKER) |-> (payload_byte == 8'h00))
        else $error("event marker with nonzero byte");

    // only a separator can precede another result of the same beat
    a_first_is_sep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> (out_kind == OUT_PAYLOAD) && (payload_byte == CHAR_LF))
        else $error("leading result of a pair is not a separator");

endmodule

bind sse_event_data_extractor sseext_checker u_sseext_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .stream_byte  (stream_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .payload_byte (payload_byte),
    .last_of_run  (last_of_run)
);

[tb/sse_event_data_extractor_tb.sv]
// ----------------------------------------------------------------------------
// sse_event_data_extractor_tb
// Self-checking bench for the server-sent-events data extractor. Feeds
// directed and random byte streams (byte-order marks, data and other lines,
// mixed line ends, noise, flushes) under random sender gaps and receiver
// stalls, and checks every output beat against a built-in parser model.
// ----------------------------------------------------------------------------
module sse_event_data_extractor_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sseext_pkg::*;

    // Cycles without any accepted beat before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    // Random items per idling phase; the three phases add up to ~1260 beats.
    localparam int PHASE_ITEMS    = 420;

    // ------------------------------------------------------------------------
    // Payload tracker: runs its own copy of the line parser on every accepted
    // input beat and keeps the output beats that must follow, in order.
    // ------------------------------------------------------------------------
    class payload_tracker;
        phase_t      line_pos;
        logic [1:0]  mark_seen;
        bit          cr_pending;
        bit          has_payload;
        result_t     expected_out_q[$];
        result_t     beat_out_q[$];
        int          errors;
        int          in_beats;
        int          flushes;
        int          out_beats;
        int          markers;

        function new();
            restart();
            errors    = 0;
            in_beats  = 0;
            flushes   = 0;
            out_beats = 0;
            markers   = 0;
        endfunction

        function void restart();
            line_pos    = PH_START;
            mark_seen   = 2'd0;
            cr_pending  = 1'b0;
            has_payload = 1'b0;
        endfunction

        function void add_out(logic k, logic [7:0] d);
            result_t r;
            r.kind = k;
            r.data = d;
            r.last = 1'b0;
            beat_out_q.insert(beat_out_q.size(), r);
        endfunction

        // LF separator only once the event already carries payload
        function void add_separator();
            if (has_payload)
                add_out(OUT_PAYLOAD, CHAR_LF);
        endfunction

        function void close_line();
            if (line_pos == PH_START)
            begin
                if (has_payload)
                begin
                    add_out(OUT_MARKER, 8'h00);
                    has_payload = 1'b0;
                end
            end
            else if (line_pos == PH_DATA || line_pos == PH_COLON)
                add_separator();
            line_pos = PH_START;
        endfunction

        function void line_char(logic [7:0] c);
            case (line_pos)
                PH_START: line_pos = (c == CHAR_D)     ? PH_D     : PH_SKIP;
                PH_D:     line_pos = (c == CHAR_A)     ? PH_DA    : PH_SKIP;
                PH_DA:    line_pos = (c == CHAR_T)     ? PH_DAT   : PH_SKIP;
                PH_DAT:   line_pos = (c == CHAR_A)     ? PH_DATA  : PH_SKIP;
                PH_DATA:  line_pos = (c == CHAR_COLON) ? PH_COLON : PH_SKIP;
                PH_COLON:
                begin
                    // one space after the colon is dropped
                    add_separator();
                    if (c != CHAR_SPACE)
                    begin
                        add_out(OUT_PAYLOAD, c);
                        has_payload = 1'b1;
                    end
                    line_pos = PH_VALUE;
                end
                PH_VALUE:
                begin
                    add_out(OUT_PAYLOAD, c);
                    has_payload = 1'b1;
                end
                default:  line_pos = PH_SKIP;
            endcase
        endfunction

        function void accept_beat(logic k, logic [7:0] c);
            logic [7:0] mark;
            bit         swallowed;
            swallowed = 1'b0;
            beat_out_q.delete();
            in_beats++;
            if (k == KIND_FLUSH)
            begin
                flushes++;
                if (line_pos == PH_DATA || line_pos == PH_COLON)
                    add_separator();
                if (has_payload)
                    add_out(OUT_MARKER, 8'h00);
                restart();
            end
            else
            begin
                if (mark_seen != BOM_DONE)
                begin
                    mark = (mark_seen == 2'd0) ? BOM_B0 :
                           (mark_seen == 2'd1) ? BOM_B1 : BOM_B2;
                    if (c == mark)
                    begin
                        mark_seen = mark_seen + 2'd1;
                        swallowed = 1'b1;
                    end
                    else
                    begin
                        // broken mark: its bytes started a non-data line
                        if (mark_seen != 2'd0)
                            line_pos = PH_SKIP;
                        mark_seen = BOM_DONE;
                    end
                end
                if (!swallowed)
                begin
                    if (c == CHAR_CR)
                    begin
                        close_line();
                        cr_pending = 1'b1;
                    end
                    else if (c == CHAR_LF)
                    begin
                        if (!cr_pending)
                            close_line();
                        cr_pending = 1'b0;
                    end
                    else
                    begin
                        cr_pending = 1'b0;
                        line_char(c);
                    end
                end
            end
            if (beat_out_q.size() > 0)
                beat_out_q[beat_out_q.size() - 1].last = 1'b1;
            foreach (beat_out_q[i])
                expected_out_q.insert(expected_out_q.size(), beat_out_q[i]);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("[%0t] MISMATCH %s", $realtime, msg);
        endfunction

        function void check_beat(logic k, logic [7:0] d, logic l);
            result_t want;
            out_beats++;
            if (k == OUT_MARKER)
                markers++;
            if (expected_out_q.size() == 0)
            begin
                flag($sformatf("unexpected beat kind=%0d byte=%02h last=%0d", k, d, l));
            end
            else
            begin
                want = expected_out_q.pop_front();
                if (want.kind !== k || want.data !== d || want.last !== l)
                    flag($sformatf(
                        "exp kind=%0d byte=%02h last=%0d, got kind=%0d byte=%02h last=%0d",
                        want.kind, want.data, want.last, k, d, l));
            end
        endfunction

        function int pending();
            return expected_out_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       kind;
    logic [7:0] stream_byte;
    logic       out_valid;
    logic       out_stall;
    logic       out_kind;
    logic [7:0] payload_byte;
    logic       last_of_run;

    payload_tracker tracker = new();

    int send_gap_pct;     // chance per beat, drawn again after each idle, that the sender idles
    int recv_stall_pct;   // chance per cycle that the receiver stalls
    int beats_sent;
    int idle_cycles = 0;
    bit at_stream_start;  // next byte may open a byte-order mark

    sse_event_data_extractor u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .stream_byte  (stream_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_kind     (out_kind),
        .payload_byte (payload_byte),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stall each cycle at the current rate.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // ------------------------------------------------------------------------
    // Monitor and watchdog. Everything here samples pre-edge values, since the
    // bench and the block both update on the clock through nonblocking writes.
    // The input beat is noted before the output check in the same edge; the
    // block cannot return a result in the cycle it takes the input anyway.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.accept_beat(kind, stream_byte);
            if (out_valid && !out_stall)
                tracker.check_beat(out_kind, payload_byte, last_of_run);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no beat for %0d cycles, %0d results outstanding",
                         $realtime, idle_cycles, tracker.pending());
                $display("sse_event_data_extractor_tb: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. send_item returns in the step of the accepting edge, so
    // the next call either keeps valid high with a new payload or drops it
    // for a gap: never both in one step.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic k, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        stream_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(KIND_BYTE, b);
        at_stream_start = 1'b0;
    endtask

    // stream_byte is don't-care on a flush, so it carries random bits
    task automatic send_flush();
        send_item(KIND_FLUSH, 8'($urandom_range(0, 255)));
        at_stream_start = 1'b1;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_line_end();
        case ($urandom_range(0, 2))
            0:       send_byte(CHAR_CR);
            1:       send_byte(CHAR_LF);
            default:
            begin
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
        endcase
    endtask

    // Mostly printable; sometimes any byte that does not end the line.
    function automatic logic [7:0] value_char();
        logic [7:0] c;
        if ($urandom_range(0, 99) < 85)
            c = 8'($urandom_range(32, 126));
        else
        begin
            c = 8'($urandom_range(0, 255));
            if (c == CHAR_CR || c == CHAR_LF)
                c = c ^ 8'h80;
        end
        return c;
    endfunction

    // Whether a value may follow the prefix just sent: only after the colon.
    function automatic bit s_has_value();
        return tracker.line_pos == PH_COLON || tracker.line_pos == PH_VALUE ||
               stream_byte == CHAR_COLON || stream_byte == CHAR_SPACE;
    endfunction

    // One random chunk of stream: mostly well-formed lines with random
    // content, plus foreign fields, raw noise and flushes.
    task automatic send_random_line();
        int sel;
        int len;
        sel = $urandom_range(0, 99);

        // byte-order mark at stream start: whole, broken, or absent
        if (at_stream_start)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    send_byte(BOM_B0);
                    send_byte(BOM_B1);
                    send_byte(BOM_B2);
                end
                3:       send_byte(BOM_B0);
                4:
                begin
                    send_byte(BOM_B0);
                    send_byte(BOM_B1);
                end
                default: ;
            endcase
        end

        if (sel < 50)
        begin
            // data line; bare "data" only ever has an empty value
            case ($urandom_range(0, 4))
                0:       send_text("data");
                1, 2:    send_text("data:");
                default: send_text("data: ");
            endcase
            if (s_has_value())
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40)
                                                   : $urandom_range(0, 8);
                repeat (len)
                    send_byte(value_char());
            end
            send_line_end();
        end
        else if (sel < 66)
            send_line_end();                     // empty line closes the event
        else if (sel < 78)
        begin
            case ($urandom_range(0, 6))
                0:       send_text("event: msg");
                1:       send_text("id: 42");
                2:       send_text(": keepalive");
                3:       send_text("dataX");
                4:       send_text("data x");
                5:       send_text("retry: 100");
                default: send_text("dat");
            endcase
            send_line_end();
        end
        else if (sel < 93)
        begin
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom_range(0, 255)));
        end
        else
            send_flush();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        kind           <= KIND_BYTE;
        stream_byte    <= 8'h00;
        send_gap_pct   <= 32;
        recv_stall_pct <= 53;
        beats_sent      = 0;
        at_stream_start = 1'b1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // -- directed part --
        // full mark is dropped, value holds both byte extremes, CRLF is
        // one line end
        send_byte(BOM_B0);
        send_byte(BOM_B1);
        send_byte(BOM_B2);
        send_text("data:");
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        // empty data value on a non-empty payload: separator only
        send_text("data");
        send_byte(CHAR_LF);
        // foreign field is skipped whole
        send_text("dx");
        send_byte(CHAR_CR);
        // flush on a pending "data:": separator then marker, two results
        send_text("data:");
        send_item(KIND_FLUSH, 8'hFF);
        at_stream_start = 1'b1;
        // broken mark starts a skipped line; then an empty line on an empty
        // event gives no marker
        send_byte(BOM_B0);
        send_byte(BOM_B1);
        send_byte(CHAR_A);
        send_byte(CHAR_LF);
        send_byte(CHAR_LF);

        // -- random part, three idling phases --
        while (beats_sent < PHASE_ITEMS)
            send_random_line();

        send_gap_pct   <= 53;
        recv_stall_pct <= 32;
        while (beats_sent < 2 * PHASE_ITEMS)
            send_random_line();

        send_gap_pct   <= 0;
        recv_stall_pct <= 0;
        while (beats_sent < 3 * PHASE_ITEMS)
            send_random_line();
        send_flush();
        in_valid <= 1'b0;

        // drain, then leave time for any stray beat to show up
        do
            @(posedge clk);
        while (tracker.pending() != 0);
        repeat (16) @(posedge clk);

        $display("covered %0d input beats (%0d flushes), %0d output beats checked, %0d events",
                 tracker.in_beats, tracker.flushes, tracker.out_beats, tracker.markers);
        $display("mismatches: %0d", tracker.errors);
        if (tracker.errors == 0)
            $display("sse_event_data_extractor_tb: clean");
        else
            $display("sse_event_data_extractor_tb: errors");
        $finish;
    end

endmodule
